/* rtl/assert_macros.svh */
// assert_macros.svh: assertion macros shared by the RTL files.
// Assertions compile out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/ddo_pkg.sv */
// ddo_pkg.sv: constants and types for the differential-drive odometry unit.
// No dependencies.
package ddo_pkg;
    localparam int unsigned CordicSteps = 24;
    localparam logic [31:0] SpeedGainRst = 32'd449767924;
    localparam logic [23:0] InvTrackRst = 24'd65536;
    localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    localparam logic [1:0] OpLeft = 2'd0;
    localparam logic [1:0] OpRight = 2'd1;
    localparam logic [1:0] OpStep = 2'd2;
    localparam logic [1:0] OpRsvd = 2'd3;

    localparam logic CfgSpeedGain = 1'b0;
    localparam logic CfgInvTrack = 1'b1;

    function automatic logic signed [33:0] atan_tab(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0: v = 34'sd536870912;   5'd1: v = 34'sd316933406;
            5'd2: v = 34'sd167458907;   5'd3: v = 34'sd85004756;
            5'd4: v = 34'sd42667331;    5'd5: v = 34'sd21354465;
            5'd6: v = 34'sd10679838;    5'd7: v = 34'sd5340245;
            5'd8: v = 34'sd2670163;     5'd9: v = 34'sd1335087;
            5'd10: v = 34'sd667544;     5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;     5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;      5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;      5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;       5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;        5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;        5'd23: v = 34'sd81;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

/* rtl/diff_drive_odometry_unit.sv */
// diff_drive_odometry_unit.sv: differential-drive odometry with a shared
// 33x33 multiplier and an iterative CORDIC. Uses ddo_pkg, assert_macros.svh.
//
//  channel | dir | fields
//  s_axis  | in  | tuser: op[1:0]; tdata: wheel_rpm[23:0], elapsed_time[43:24]
//  m_axis  | out | tdata: pos_x, pos_y, heading, lin_vel, ang_vel (32 b each)
//  cfg     | in  | index 0 speed_gain, 1 inv_axle_track
//
// One shared signed 33x33 multiply per cycle. A wheel request passes through
// the speed and wz states before its result is offered, the reserved op only
// through wz, and a step request through wz, three heading multiplies, CORDIC
// load, 24 iterations, distance, four position multiplies and the y update.
// The next request can be taken in the cycle after the result is taken.
// One request in flight; s_axis_tready is low from acceptance until the result
// is taken. Synchronous active-low reset.
`include "assert_macros.svh"
module diff_drive_odometry_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0]
    input  logic [1:0]   s_axis_tuser,
    // wheel_rpm[23:0], elapsed_time[43:24], zero pad
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x[31:0], pos_y[63:32], heading[95:64], lin_vel[127:96], ang_vel[159:128]
    output logic [159:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata
);
    typedef enum logic [3:0] {
        S_IDLE, S_SPD, S_WZ, S_DT0, S_DT1, S_DT2, S_CLD, S_COR, S_D,
        S_DXL, S_DXH, S_DYL, S_DYH, S_PY, S_OUT
    } t_state;

    t_state r_state;
    logic [1:0] r_op;
    logic signed [23:0] r_rpm;
    logic [19:0] r_dt;
    logic [31:0] r_gain;
    logic [23:0] r_inv;
    logic signed [31:0] r_left, r_right, r_px, r_py, r_vx, r_wz;
    logic [31:0] r_head;
    logic signed [63:0] r_acc;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic [4:0] r_it;
    logic [1:0] r_q;
    logic signed [63:0] r_d;
    logic signed [23:0] r_c20, r_s20;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [32:0] diff_lr;
    logic signed [32:0] sum_lr;
    logic signed [31:0] cos_v, sin_v;
    logic [31:0] q_base;
    logic signed [33:0] cz0;

    assign sum_lr = 33'(r_left) + 33'(r_right);
    assign diff_lr = 33'(r_right) - 33'(r_left);
    assign q_base = r_head + 32'h2000_0000;
    assign cz0 = 34'(signed'(r_head - {q_base[31:30], 30'd0}));

    always_comb begin
        case (r_q)
            2'd0: begin cos_v = r_cx[31:0]; sin_v = r_cy[31:0]; end
            2'd1: begin cos_v = -r_cy[31:0]; sin_v = r_cx[31:0]; end
            2'd2: begin cos_v = -r_cx[31:0]; sin_v = -r_cy[31:0]; end
            default: begin cos_v = r_cy[31:0]; sin_v = -r_cx[31:0]; end
        endcase
    end

    // Operand select for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SPD: begin mul_a = 33'(r_rpm); mul_b = {1'b0, r_gain}; end
            S_WZ:  begin mul_a = diff_lr; mul_b = 33'({9'd0, r_inv}); end
            S_DT0: begin mul_a = 33'(r_wz); mul_b = 33'({13'd0, r_dt}); end
            // (wz*dt) mod 2^64 times K, upper 32 of low 64: low*K + (high*K)<<32
            S_DT1: begin mul_a = {1'b0, r_acc[31:0]}; mul_b = {1'b0, ddo_pkg::InvTwoPiQ32}; end
            S_DT2: begin mul_a = {1'b0, r_acc[63:32]}; mul_b = {1'b0, ddo_pkg::InvTwoPiQ32}; end
            S_D:   begin mul_a = 33'(r_vx); mul_b = 33'({13'd0, r_dt}); end
            // distance split in a low unsigned and a high signed half
            S_DXL: begin mul_a = {1'b0, r_d[31:0]}; mul_b = 33'(r_c20); end
            S_DXH: begin mul_a = 33'(signed'(r_d[63:32])); mul_b = 33'(r_c20); end
            S_DYL: begin mul_a = {1'b0, r_d[31:0]}; mul_b = 33'(r_s20); end
            S_DYH: begin mul_a = 33'(signed'(r_d[63:32])); mul_b = 33'(r_s20); end
            default: ;
        endcase
    end

    logic signed [33:0] ysh, xsh;
    assign ysh = r_cy >>> r_it;
    assign xsh = r_cx >>> r_it;

    logic signed [63:0] wz_full;
    logic [63:0] lo_prod;
    assign wz_full = 64'(mul_p >>> 16);
    assign lo_prod = 64'(unsigned'(mul_p));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gain <= ddo_pkg::SpeedGainRst;
            r_inv <= ddo_pkg::InvTrackRst;
            r_left <= '0; r_right <= '0; r_px <= '0; r_py <= '0;
            r_head <= '0; r_vx <= '0; r_wz <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ddo_pkg::CfgSpeedGain: r_gain <= i_cfg_wdata;
                    ddo_pkg::CfgInvTrack: r_inv <= i_cfg_wdata[23:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_op <= s_axis_tuser;
                    r_rpm <= s_axis_tdata[23:0];
                    r_dt <= s_axis_tdata[43:24];
                    r_state <= (s_axis_tuser inside {ddo_pkg::OpLeft, ddo_pkg::OpRight}) ?
                               S_SPD : S_WZ;
                end
                S_SPD: begin
                    if (r_op == ddo_pkg::OpLeft) r_left <= 32'(mul_p >>> 24);
                    else r_right <= 32'(mul_p >>> 24);
                    r_state <= S_WZ;
                end
                S_WZ: begin
                    r_vx <= sum_lr[32:1];
                    r_wz <= ddo_pkg::sat32(wz_full);
                    r_state <= (r_op == ddo_pkg::OpStep) ? S_DT0 : S_OUT;
                end
                S_DT0: begin r_acc <= 64'(mul_p); r_state <= S_DT1; end
                S_DT1: begin r_d <= lo_prod; r_state <= S_DT2; end
                S_DT2: begin
                    r_head <= r_head + r_d[63:32] + lo_prod[31:0];
                    r_state <= S_CLD;
                end
                S_CLD: begin
                    // residual angle and quadrant of the updated heading
                    r_cx <= ddo_pkg::CordicGain;
                    r_cy <= '0;
                    r_cz <= cz0;
                    r_q <= q_base[31:30];
                    r_it <= '0;
                    r_state <= S_COR;
                end
                S_COR: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - ysh; r_cy <= r_cy + xsh;
                        r_cz <= r_cz - ddo_pkg::atan_tab(r_it);
                    end else begin
                        r_cx <= r_cx + ysh; r_cy <= r_cy - xsh;
                        r_cz <= r_cz + ddo_pkg::atan_tab(r_it);
                    end
                    r_it <= r_it + 5'd1;
                    if (r_it == 5'(ddo_pkg::CordicSteps - 1)) r_state <= S_D;
                end
                S_D: begin
                    r_d <= 64'(mul_p >>> 10);
                    r_c20 <= 24'(cos_v >>> 10);
                    r_s20 <= 24'(sin_v >>> 10);
                    r_state <= S_DXL;
                end
                S_DXL: begin
                    r_acc <= 64'(mul_p);
                    r_state <= S_DXH;
                end
                S_DXH: begin
                    r_acc <= r_acc + {mul_p[31:0], 32'd0};
                    r_state <= S_DYL;
                end
                S_DYL: begin
                    r_px <= ddo_pkg::sat32(64'(r_px) + (r_acc >>> 26));
                    r_acc <= 64'(mul_p);
                    r_state <= S_DYH;
                end
                S_DYH: begin
                    r_acc <= r_acc + {mul_p[31:0], 32'd0};
                    r_state <= S_PY;
                end
                S_PY: begin
                    r_py <= ddo_pkg::sat32(64'(r_py) + (r_acc >>> 26));
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {r_wz, r_vx, r_head, r_py, r_px};

    `ASSERT_CLK(a_excl, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
    `ASSERT_CLK(a_cor_end, i_clk, i_rst_n, (r_state == S_D) |-> ($past(r_state) == S_COR), "CORDIC skipped")
    `ASSERT_CLK(a_acc, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "accepted twice")
endmodule

/* bench/diff_drive_odometry_unit_tb.sv */
// diff_drive_odometry_unit_tb.sv: self-checking bench for the odometry unit.
// Predicts pose and velocities per request and checks each output beat.
// Depends on ddo_pkg and diff_drive_odometry_unit.
`timescale 1ns / 1ps
module diff_drive_odometry_unit_tb;

    typedef struct packed {
        logic [31:0] ang_vel;
        logic [31:0] lin_vel;
        logic [31:0] heading;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } t_pose;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser = '0;
    logic [47:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = 1'b0;
    logic [31:0]  i_cfg_wdata = '0;

    diff_drive_odometry_unit u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // request: op[49:48], pad, elapsed_time[43:24], wheel_rpm[23:0]
    logic [49:0] req_q[$];
    t_pose       pose_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          hold_off = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          n_pushed = 0;
    int          n_done = 0;

    // predictor state
    logic [31:0]        gain_r;
    logic [23:0]        track_r;
    logic signed [31:0] spd_l, spd_r, px, py;
    logic [31:0]        hdg;

    function automatic logic signed [63:0] shr(input logic signed [63:0] v, input int n);
        return v >>> n;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [33:0] arctan(input int i);
        logic signed [33:0] t[24];
        t = '{34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
              34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
              34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
              34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430,
              34'sd5215, 34'sd2608, 34'sd1304, 34'sd652, 34'sd326, 34'sd163,
              34'sd81};
        return t[i];
    endfunction

    task automatic rotate_heading(input logic [31:0] a,
                                  output logic signed [63:0] c,
                                  output logic signed [63:0] s);
        logic [1:0]         q;
        logic [31:0]        rr;
        logic signed [63:0] x, y, z, nx;
        q = 2'((a + 32'h2000_0000) >> 30);
        rr = a - ({30'd0, q} << 30);
        z = 64'(signed'(rr));
        x = 64'(ddo_pkg::CordicGain);
        y = 0;
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - shr(y, i);
                y = y + shr(x, i);
                z = z - 64'(arctan(i));
            end else begin
                nx = x + shr(y, i);
                y = y - shr(x, i);
                z = z + 64'(arctan(i));
            end
            x = nx;
        end
        case (q)
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic predict_pose(input logic [49:0] d);
        logic [1:0]         op;
        logic signed [63:0] rpm, dt, vx, wz, c, s, travel, sp;
        logic [63:0]        prod;
        t_pose              p;
        op = d[49:48];
        rpm = 64'(signed'(d[23:0]));
        dt = 64'(d[43:24]);
        if (op == ddo_pkg::OpLeft || op == ddo_pkg::OpRight) begin
            sp = shr(rpm * $signed({32'd0, gain_r}), 24);
            if (op == ddo_pkg::OpLeft) spd_l = sp[31:0];
            else spd_r = sp[31:0];
        end
        vx = shr(64'(spd_l) + 64'(spd_r), 1);
        wz = 64'(clamp32(shr((64'(spd_r) - 64'(spd_l)) * $signed({40'd0, track_r}), 16)));
        if (op == ddo_pkg::OpStep) begin
            prod = 64'(wz * dt) * 64'(ddo_pkg::InvTwoPiQ32);
            hdg = hdg + prod[63:32];
            rotate_heading(hdg, c, s);
            travel = shr(vx * dt, 10);
            px = clamp32(64'(px) + shr(travel * shr(c, 10), 26));
            py = clamp32(64'(py) + shr(travel * shr(s, 10), 26));
        end
        p.pos_x = px;
        p.pos_y = py;
        p.heading = hdg;
        p.lin_vel = vx[31:0];
        p.ang_vel = wz[31:0];
        pose_q.push_back(p);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, exp);
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pose({s_axis_tuser, s_axis_tdata});
                send_gap = rand_gap();
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap == 0 && req_q.size() > 0) begin
                    {s_axis_tuser, s_axis_tdata} <= req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    if (send_gap > 0) send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pose got, exp;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                n_done++;
                if (pose_q.size() == 0) begin
                    report("unexpected result", got.pos_x, 32'd0);
                end else begin
                    exp = pose_q.pop_front();
                    if (got.pos_x !== exp.pos_x) report("pos_x", got.pos_x, exp.pos_x);
                    if (got.pos_y !== exp.pos_y) report("pos_y", got.pos_y, exp.pos_y);
                    if (got.heading !== exp.heading) report("heading", got.heading, exp.heading);
                    if (got.lin_vel !== exp.lin_vel) report("lin_vel", got.lin_vel, exp.lin_vel);
                    if (got.ang_vel !== exp.ang_vel) report("ang_vel", got.ang_vel, exp.ang_vel);
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready) recv_gap = rand_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("diff_drive_odometry_unit_tb failed");
            $finish;
        end
    end

    function automatic logic [49:0] pack_req(input logic [1:0] op, input logic [23:0] rpm,
                                             input logic [19:0] dt);
        return {op, 4'd0, dt, rpm};
    endfunction

    task automatic push_req(input logic [1:0] op, input logic [23:0] rpm,
                            input logic [19:0] dt);
        req_q.push_back(pack_req(op, rpm, dt));
        n_pushed++;
    endtask

    function automatic logic [23:0] rand_rpm();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(0, 4000)) - 2000);
            2: return 24'($signed($urandom_range(0, 400000)) - 200000);
            default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        endcase
    endfunction

    task automatic wait_drained();
        while (n_done != n_pushed) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ddo_pkg::CfgSpeedGain) gain_r = val;
        else track_r = val[23:0];
    endtask

    task automatic random_phase(input int n);
        logic [1:0] op;
        for (int i = 0; i < n; i++) begin
            op = 2'($urandom_range(0, 9) < 7 ? $urandom_range(0, 2) : $urandom_range(0, 3));
            push_req(op, rand_rpm(),
                $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(0, 2000)));
        end
        wait_drained();
    endtask

    initial begin
        gain_r = ddo_pkg::SpeedGainRst;
        track_r = ddo_pkg::InvTrackRst;
        spd_l = 0; spd_r = 0; px = 0; py = 0; hdg = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, every op, reserved op, unused fields
        push_req(ddo_pkg::OpStep, 24'h7FFFFF, 20'd0);
        push_req(ddo_pkg::OpLeft, 24'h7FFFFF, 20'hFFFFF);
        push_req(ddo_pkg::OpRight, 24'h800000, 20'hFFFFF);
        push_req(ddo_pkg::OpStep, 24'h800000, 20'hFFFFF);
        push_req(ddo_pkg::OpStep, 24'h000000, 20'hFFFFF);
        push_req(ddo_pkg::OpRsvd, 24'hFFFFFF, 20'hFFFFF);
        push_req(ddo_pkg::OpLeft, 24'h000000, 20'd0);
        push_req(ddo_pkg::OpRight, 24'h7FFFFF, 20'd0);
        for (int i = 0; i < 6; i++) push_req(ddo_pkg::OpStep, 24'd0, 20'hFFFFF);
        push_req(ddo_pkg::OpLeft, 24'h7FFFFF, 20'd0);
        for (int i = 0; i < 6; i++) push_req(ddo_pkg::OpStep, 24'd0, 20'hFFFFF);
        wait_drained();
        // long receiver hold-off with input still offered
        hold_off = 400;
        random_phase(200);
        write_cfg(ddo_pkg::CfgSpeedGain, 32'hFFFFFFFF);
        write_cfg(ddo_pkg::CfgInvTrack, 32'h00FFFFFF);
        random_phase(200);
        write_cfg(ddo_pkg::CfgSpeedGain, 32'd0);
        write_cfg(ddo_pkg::CfgInvTrack, 32'd1);
        random_phase(100);
        write_cfg(ddo_pkg::CfgInvTrack, 32'd0);
        write_cfg(ddo_pkg::CfgSpeedGain, $urandom);
        random_phase(100);
        write_cfg(ddo_pkg::CfgSpeedGain, ddo_pkg::SpeedGainRst);
        write_cfg(ddo_pkg::CfgInvTrack, 32'($urandom_range(1, 24'hFFFFFF)));
        random_phase(300);
        if (errors == 0) $display("diff_drive_odometry_unit_tb passed");
        else $display("diff_drive_odometry_unit_tb failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/ddo_pkg.sv
rtl/diff_drive_odometry_unit.sv
bench/diff_drive_odometry_unit_tb.sv
